// ===== rtl/core/dspa_pkg.sv =====
package dspa_pkg;

	// byte event kinds carried in the slave-side tuser
	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// function-layer phase
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_CMD   = 3'd1,
		PH_READ  = 3'd2,
		PH_WDATA = 3'd3,
		PH_WCFM  = 3'd4,
		PH_WACK  = 3'd5,
		PH_WSTAT = 3'd6
	} phase_t;

	localparam logic [7:0] CMD_READ  = 8'hF5;
	localparam logic [7:0] CMD_WRITE = 8'h5A;
	localparam logic [7:0] ACK_BYTE  = 8'hAA;
	localparam logic [7:0] IDLE_BYTE = 8'hFF;

	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 16;
	localparam int unsigned OUT_USER_W = 1;

	// one byte event
	typedef struct packed {
		mode_t      mode;
		logic [7:0] rx_byte;
		logic       pin_a;
		logic       pin_b;
	} evt_t;

	// one result item
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       latch_a;
		logic       latch_b;
		logic       confirm_failed;
	} res_t;

	// status byte: pins and latches in the low nibble, complement above
	function automatic logic [7:0] status_byte(input logic pa, input logic la,
		input logic pb, input logic lb);
		logic [3:0] lo;
		lo = {lb, pb, la, pa};
		return {~lo, lo};
	endfunction

endpackage

// ===== rtl/core/dspa_core.sv =====
module dspa_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  dspa_pkg::evt_t evt,
	output dspa_pkg::res_t res
);

	dspa_pkg::phase_t phase_q, phase_d;
	logic             out_a_q, out_a_d;
	logic             out_b_q, out_b_d;
	logic [7:0]       pending_q;
	logic             pend_we;
	logic             cfm_match;

	assign cfm_match = (~evt.rx_byte) == pending_q;

	// next state
	always_comb begin
		phase_d = phase_q;
		out_a_d = out_a_q;
		out_b_d = out_b_q;
		pend_we = 1'b0;
		case (evt.mode)
			dspa_pkg::MODE_START: begin
				phase_d = dspa_pkg::PH_CMD;
			end
			dspa_pkg::MODE_WRITE: begin
				case (phase_q)
					dspa_pkg::PH_CMD: begin
						if (evt.rx_byte == dspa_pkg::CMD_READ) begin
							phase_d = dspa_pkg::PH_READ;
						end else if (evt.rx_byte == dspa_pkg::CMD_WRITE) begin
							phase_d = dspa_pkg::PH_WDATA;
						end else begin
							phase_d = dspa_pkg::PH_IDLE;
						end
					end
					dspa_pkg::PH_WDATA: begin
						pend_we = 1'b1;
						phase_d = dspa_pkg::PH_WCFM;
					end
					dspa_pkg::PH_WCFM: begin
						if (cfm_match) begin
							out_a_d = pending_q[0];
							out_b_d = pending_q[1];
							phase_d = dspa_pkg::PH_WACK;
						end else begin
							phase_d = dspa_pkg::PH_IDLE;
						end
					end
					default: ;
				endcase
			end
			dspa_pkg::MODE_READ: begin
				case (phase_q)
					dspa_pkg::PH_WACK:  phase_d = dspa_pkg::PH_WSTAT;
					dspa_pkg::PH_WSTAT: phase_d = dspa_pkg::PH_WDATA;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// result fields
	always_comb begin
		res.tx_valid       = 1'b0;
		res.tx_byte        = 8'h00;
		res.latch_a        = out_a_d;
		res.latch_b        = out_b_d;
		res.confirm_failed = 1'b0;
		case (evt.mode)
			dspa_pkg::MODE_WRITE: begin
				res.confirm_failed = (phase_q == dspa_pkg::PH_WCFM) && !cfm_match;
			end
			dspa_pkg::MODE_READ: begin
				res.tx_valid = 1'b1;
				case (phase_q)
					dspa_pkg::PH_READ, dspa_pkg::PH_WSTAT: begin
						res.tx_byte = dspa_pkg::status_byte(evt.pin_a, out_a_q,
							evt.pin_b, out_b_q);
					end
					dspa_pkg::PH_WACK: res.tx_byte = dspa_pkg::ACK_BYTE;
					default:           res.tx_byte = dspa_pkg::IDLE_BYTE;
				endcase
			end
			default: ;
		endcase
	end

	// phase and latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dspa_pkg::PH_IDLE;
			out_a_q <= 1'b1;
			out_b_q <= 1'b1;
		end else if (en) begin
			phase_q <= phase_d;
			out_a_q <= out_a_d;
			out_b_q <= out_b_d;
		end
	end

	// received data byte, held for the complement check
	always_ff @(posedge clk) begin
		if (en && pend_we) begin
			pending_q <= evt.rx_byte;
		end
	end

endmodule

// ===== rtl/core/dual_switch_pio_access_unit.sv =====
// Function-command layer of a two-channel addressable switch on a single-wire bus.
// Slave-side stream: one transaction per byte event; tuser holds the event kind
// (start after ROM select, byte written by the master, master read slot, none),
// tdata holds the written byte and the sensed levels of pins A and B.
// Master-side stream: exactly one transaction per accepted event, in order;
// tuser says whether a byte is driven for a read slot, tdata holds that byte
// (status, 0xAA confirm or 0xFF), both output latches after the event and the
// confirm-failed flag.
// An accepted event is held in the input register, and its result is taken into
// the result register when the result side can advance.
// Throughput: one event per cycle while results are taken; the command logic is
// combinational, and the phase updates at the edge that registers the result.
// Reset: the phase waits for a transaction start, both latches are released
// high and both stream stages are empty.
// Stall: while a result waits in the output register the input register still
// takes one more event; s_axis_tready falls only when both registers are full.
module dual_switch_pio_access_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // rx_byte[7:0], pin_a[8], pin_b[9], zero fill
	input  logic [1:0]  s_axis_tuser,  // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // tx_byte[7:0], latch_a[8], latch_b[9],
	                                   // confirm_failed[10], zero fill
	output logic [0:0]  m_axis_tuser   // tx_valid[0]
);

	logic           valid_s1;
	dspa_pkg::evt_t evt_s1;
	logic           valid_s2;
	dspa_pkg::res_t res_s2;
	dspa_pkg::res_t res_c;
	logic           advance;
	logic           step;

	assign advance       = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			evt_s1.mode    <= dspa_pkg::mode_t'(s_axis_tuser);
			evt_s1.rx_byte <= s_axis_tdata[7:0];
			evt_s1.pin_a   <= s_axis_tdata[8];
			evt_s1.pin_b   <= s_axis_tdata[9];
		end
	end

	// command logic and switch state
	dspa_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step),
		.evt    (evt_s1),
		.res    (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_c;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.tx_valid;
	assign m_axis_tdata  = {5'd0, res_s2.confirm_failed, res_s2.latch_b,
		res_s2.latch_a, res_s2.tx_byte};

endmodule

// ===== rtl/core/dspa_checker.sv =====
module dspa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// an offered event transaction waits unchanged until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
		s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
		else $error("event changed while waiting");

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// no byte driven outside a read slot
	a_quiet_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'h00)
		else $error("tx byte set without a read slot");

	// a confirm failure comes from a written byte, never a read slot
	a_fail_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[10] |-> !m_axis_tuser[0])
		else $error("confirm failure on a read slot");

	// a driven byte is a status byte, the confirm byte or the idle byte
	a_tx_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
		(m_axis_tdata[7:4] == ~m_axis_tdata[3:0]) ||
		(m_axis_tdata[7:0] == dspa_pkg::ACK_BYTE) ||
		(m_axis_tdata[7:0] == dspa_pkg::IDLE_BYTE))
		else $error("malformed tx byte");

endmodule

bind dual_switch_pio_access_unit dspa_checker u_dspa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== sim/pio_access_check.sv =====
`timescale 1ns / 100ps

module pio_access_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        evt_valid,
	input  logic        evt_ready,
	input  logic [15:0] evt_data,   // rx_byte[7:0], pin_a[8], pin_b[9], zero fill
	input  logic [1:0]  evt_kind,   // mode[1:0]
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [15:0] res_data,   // tx_byte[7:0], latch_a[8], latch_b[9], confirm_failed[10]
	input  logic [0:0]  res_flag,   // tx_valid[0]
	output int          mismatches,
	output int          expected_left
);

	localparam int REPORT_LIMIT = 10;

	// predicted switch state
	dspa_pkg::phase_t sw_phase = dspa_pkg::PH_IDLE;
	logic             sw_latch_a = 1'b1;
	logic             sw_latch_b = 1'b1;
	logic [7:0]       sw_data_held = '0;
	dspa_pkg::res_t   pio_results_due[$];

	// advance the switch by one byte event and return what it answers
	function automatic dspa_pkg::res_t next_pio_result(input dspa_pkg::evt_t ev);
		dspa_pkg::res_t r;
		logic [3:0]     nib;
		r = '0;
		case (ev.mode)
			dspa_pkg::MODE_START: sw_phase = dspa_pkg::PH_CMD;
			dspa_pkg::MODE_WRITE: begin
				case (sw_phase)
					dspa_pkg::PH_CMD: begin
						if (ev.rx_byte == dspa_pkg::CMD_READ)
							sw_phase = dspa_pkg::PH_READ;
						else if (ev.rx_byte == dspa_pkg::CMD_WRITE)
							sw_phase = dspa_pkg::PH_WDATA;
						else
							sw_phase = dspa_pkg::PH_IDLE;
					end
					dspa_pkg::PH_WDATA: begin
						sw_data_held = ev.rx_byte;
						sw_phase = dspa_pkg::PH_WCFM;
					end
					dspa_pkg::PH_WCFM: begin
						// complement checked over the whole byte
						if ((~ev.rx_byte) == sw_data_held) begin
							sw_latch_a = sw_data_held[0];
							sw_latch_b = sw_data_held[1];
							sw_phase = dspa_pkg::PH_WACK;
						end else begin
							r.confirm_failed = 1'b1;
							sw_phase = dspa_pkg::PH_IDLE;
						end
					end
					default: ;
				endcase
			end
			dspa_pkg::MODE_READ: begin
				r.tx_valid = 1'b1;
				nib = {sw_latch_b, ev.pin_b, sw_latch_a, ev.pin_a};
				case (sw_phase)
					dspa_pkg::PH_READ: r.tx_byte = {~nib, nib};
					dspa_pkg::PH_WACK: begin
						r.tx_byte = dspa_pkg::ACK_BYTE;
						sw_phase = dspa_pkg::PH_WSTAT;
					end
					dspa_pkg::PH_WSTAT: begin
						r.tx_byte = {~nib, nib};
						sw_phase = dspa_pkg::PH_WDATA;
					end
					default: r.tx_byte = dspa_pkg::IDLE_BYTE;
				endcase
			end
			default: ;
		endcase
		r.latch_a = sw_latch_a;
		r.latch_b = sw_latch_b;
		return r;
	endfunction

	// match one result transaction against the oldest prediction
	task automatic compare_pio_result(input dspa_pkg::res_t got);
		dspa_pkg::res_t want;
		if (pio_results_due.size() == 0) begin
			if (mismatches < REPORT_LIMIT)
				$display("%t: result with nothing pending: tx_valid=%0d tx_byte=%02h",
					$realtime, got.tx_valid, got.tx_byte);
			mismatches++;
		end else begin
			want = pio_results_due.pop_front();
			if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
				got.latch_a !== want.latch_a || got.latch_b !== want.latch_b ||
				got.confirm_failed !== want.confirm_failed) begin
				if (mismatches < REPORT_LIMIT)
					$display("%t: mismatch: expected tx_valid=%0d tx_byte=%02h latch_a=%0d ",
						$realtime, want.tx_valid, want.tx_byte, want.latch_a,
						"latch_b=%0d confirm_failed=%0d, got %0d %02h %0d %0d %0d",
						want.latch_b, want.confirm_failed, got.tx_valid, got.tx_byte,
						got.latch_a, got.latch_b, got.confirm_failed);
				mismatches++;
			end
		end
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		dspa_pkg::evt_t ev;
		dspa_pkg::res_t got;
		if (!arst_n) begin
			sw_phase = dspa_pkg::PH_IDLE;
			sw_latch_a = 1'b1;
			sw_latch_b = 1'b1;
			sw_data_held = '0;
			pio_results_due.delete();
			mismatches = 0;
			expected_left <= 0;
		end else begin
			if (res_valid && res_ready) begin
				got.tx_valid       = res_flag[0];
				got.tx_byte        = res_data[7:0];
				got.latch_a        = res_data[8];
				got.latch_b        = res_data[9];
				got.confirm_failed = res_data[10];
				compare_pio_result(got);
			end
			if (evt_valid && evt_ready) begin
				ev.mode    = dspa_pkg::mode_t'(evt_kind);
				ev.rx_byte = evt_data[7:0];
				ev.pin_a   = evt_data[8];
				ev.pin_b   = evt_data[9];
				pio_results_due.push_back(next_pio_result(ev));
			end
			expected_left <= pio_results_due.size();
		end
	end

endmodule

// ===== sim/dual_switch_pio_access_unit_test.sv =====
`timescale 1ns / 100ps

module dual_switch_pio_access_unit_test;

	localparam int EVENT_TARGET = 600;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int GAP_MAX      = 19;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // rx_byte[7:0], pin_a[8], pin_b[9], zero fill
	logic [1:0]  s_axis_tuser = dspa_pkg::MODE_NONE;   // mode[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;   // tx_byte[7:0], latch_a[8], latch_b[9], confirm_failed[10]
	logic [0:0]  m_axis_tuser;   // tx_valid[0]

	int mismatches;
	int expected_left;
	int events_sent = 0;
	int sender_gap_max = GAP_MAX;
	bit hold_request = 1'b0;

	dual_switch_pio_access_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	pio_access_check result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt_valid     (s_axis_tvalid),
		.evt_ready     (s_axis_tready),
		.evt_data      (s_axis_tdata),
		.evt_kind      (s_axis_tuser),
		.res_valid     (m_axis_tvalid),
		.res_ready     (m_axis_tready),
		.res_data      (m_axis_tdata),
		.res_flag      (m_axis_tuser),
		.mismatches    (mismatches),
		.expected_left (expected_left)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic random_level();
		return logic'($urandom_range(0, 1));
	endfunction

	// offer one byte event and wait for its transaction
	task automatic offer_event(input dspa_pkg::mode_t kind, input logic [7:0] rx,
		input logic pa, input logic pb);
		int gap;
		gap = $urandom_range(0, sender_gap_max);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, pb, pa, rx};
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		if (kind != dspa_pkg::MODE_NONE)
			events_sent++;
	endtask

	task automatic offer_random(input dspa_pkg::mode_t kind, input logic [7:0] rx);
		offer_event(kind, rx, random_level(), random_level());
	endtask

	// stop offering until every result is back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
	endtask

	// one random bus transaction, mostly well formed
	task automatic offer_random_transaction();
		int         pick;
		int         reads;
		logic [7:0] data_byte;
		logic [7:0] cfm_byte;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			// pio write with a few data rounds
			offer_random(dspa_pkg::MODE_START, 8'($urandom));
			offer_random(dspa_pkg::MODE_WRITE, dspa_pkg::CMD_WRITE);
			repeat ($urandom_range(1, 4)) begin
				data_byte = 8'($urandom);
				cfm_byte = ~data_byte;
				if ($urandom_range(0, 6) == 0)
					cfm_byte = cfm_byte ^ (8'd1 << $urandom_range(0, 7));
				offer_random(dspa_pkg::MODE_WRITE, data_byte);
				offer_random(dspa_pkg::MODE_WRITE, cfm_byte);
				if ($urandom_range(0, 5) == 0)
					offer_random(dspa_pkg::MODE_WRITE, 8'($urandom));
				reads = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 2;
				repeat (reads) offer_random(dspa_pkg::MODE_READ, 8'($urandom));
			end
		end else if (pick < 70) begin
			// pio read
			offer_random(dspa_pkg::MODE_START, 8'($urandom));
			offer_random(dspa_pkg::MODE_WRITE, dspa_pkg::CMD_READ);
			repeat ($urandom_range(1, 5)) offer_random(dspa_pkg::MODE_READ, 8'($urandom));
		end else if (pick < 80) begin
			// unknown or corrupted command
			offer_random(dspa_pkg::MODE_START, 8'($urandom));
			offer_random(dspa_pkg::MODE_WRITE, 8'($urandom) ^ dspa_pkg::CMD_WRITE);
			repeat ($urandom_range(1, 3))
				offer_random(dspa_pkg::mode_t'($urandom_range(1, 2)), 8'($urandom));
		end else begin
			// noise
			repeat ($urandom_range(1, 4))
				offer_random(dspa_pkg::mode_t'($urandom_range(0, 3)), 8'($urandom));
		end
	endtask

	// result side with random stalls and one long hold-off
	initial begin
		int gap;
		int run_left;
		int gap_max;
		run_left = 0;
		gap_max = GAP_MAX;
		forever begin
			if (run_left == 0) begin
				run_left = $urandom_range(20, 60);
				gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
			end
			run_left--;
			gap = $urandom_range(0, gap_max);
			if (hold_request) begin
				hold_request = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// stimulus and verdict
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// read slot and stray write while idle, no event
		offer_event(dspa_pkg::MODE_READ, 8'h00, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_NONE, 8'hFF, 1'b1, 1'b1);
		offer_event(dspa_pkg::MODE_WRITE, dspa_pkg::CMD_WRITE, 1'b0, 1'b1);
		// pio read, write ignored while sending, start aborts
		offer_event(dspa_pkg::MODE_START, 8'h00, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_WRITE, dspa_pkg::CMD_READ, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_READ, 8'h00, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_READ, 8'hFF, 1'b1, 1'b1);
		offer_event(dspa_pkg::MODE_WRITE, 8'h00, 1'b1, 1'b0);
		offer_event(dspa_pkg::MODE_START, 8'hFF, 1'b1, 1'b1);
		// pio write: both latches low, then A low and B high with upper bits set
		offer_event(dspa_pkg::MODE_WRITE, dspa_pkg::CMD_WRITE, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_WRITE, 8'h00, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_WRITE, 8'hFF, 1'b1, 1'b1);
		offer_event(dspa_pkg::MODE_READ, 8'h00, 1'b0, 1'b1);
		offer_event(dspa_pkg::MODE_READ, 8'h00, 1'b1, 1'b0);
		offer_event(dspa_pkg::MODE_WRITE, 8'hFE, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_WRITE, 8'h01, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_READ, 8'h00, 1'b1, 1'b1);
		offer_event(dspa_pkg::MODE_READ, 8'h00, 1'b1, 1'b1);
		// complement wrong only in bit 7
		offer_event(dspa_pkg::MODE_WRITE, 8'h03, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_WRITE, 8'h7C, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_READ, 8'h00, 1'b0, 1'b0);
		// unknown command, then start twice
		offer_event(dspa_pkg::MODE_START, 8'h00, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_WRITE, 8'h00, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_START, 8'h00, 1'b0, 1'b0);
		offer_event(dspa_pkg::MODE_START, 8'h00, 1'b1, 1'b0);
		drain_results();

		// random transactions
		while (events_sent < EVENT_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				sender_gap_max = ($urandom_range(0, 1) != 0) ? GAP_MAX : 0;
			if (!hold_done && events_sent > EVENT_TARGET / 2) begin
				// back-to-back reads against a stalled result side
				hold_done = 1'b1;
				hold_request = 1'b1;
				sender_gap_max = 0;
				offer_random(dspa_pkg::MODE_START, 8'($urandom));
				offer_random(dspa_pkg::MODE_WRITE, dspa_pkg::CMD_READ);
				repeat (12) offer_random(dspa_pkg::MODE_READ, 8'($urandom));
				drain_results();
				sender_gap_max = GAP_MAX;
			end
			offer_random_transaction();
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_left == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== dual_switch_pio_access_unit.f =====
rtl/core/dspa_pkg.sv
rtl/core/dspa_core.sv
rtl/core/dual_switch_pio_access_unit.sv
rtl/core/dspa_checker.sv
sim/pio_access_check.sv
sim/dual_switch_pio_access_unit_test.sv
